### rtl/core/sssd_pkg.sv
// ----------------------------------------------------------------------------
// sssd_pkg
// Shared types, constants and segment tables for the serial display driver.
// ----------------------------------------------------------------------------
package sssd_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int WORD_W        = 32;
  localparam int OPCODE_W      = 2;
  localparam int BAR_W         = 4;
  localparam int INDEX_W       = 5;
  localparam int BIN_W         = 16;
  localparam int BCD_W         = 12;
  localparam int STEP_W        = 4;

  localparam logic [WORD_W-1:0] DP_MIDDLE = 32'h0000_0800;

  typedef enum logic [OPCODE_W-1:0] {
    OP_RAW    = 2'd0,
    OP_BAR    = 2'd1,
    OP_DP     = 2'd2,
    OP_UNUSED = 2'd3
  } opcode_t;

  function automatic logic [15:0] outer_digit(input logic [3:0] d);
    logic [15:0] p;
    unique case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] middle_digit(input logic [3:0] d);
    logic [15:0] p;
    unique case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  function automatic logic [15:0] bar_leds(input logic [BAR_W-1:0] b);
    logic [15:0] p;
    unique case (b)
      4'd0:    p = 16'h0000;
      4'd1:    p = 16'h0100;
      4'd2:    p = 16'h0300;
      4'd3:    p = 16'h0700;
      4'd4:    p = 16'h0F00;
      4'd5:    p = 16'h0F80;
      4'd6:    p = 16'h0FC0;
      4'd7:    p = 16'h0FE0;
      4'd8:    p = 16'h0FF0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

endpackage

### rtl/core/seven_segment_serial_display_driver.sv
// ----------------------------------------------------------------------------
// seven_segment_serial_display_driver
// Builds a display word from each command and shifts it out one bit at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries opcode, value and bar. Opcode
//   raw sends value as the word; the digit opcodes show the low 16 bits of
//   value as hundreds, tens and units with either a bar graph or the middle
//   decimal point.
//   Output channel (out_valid/out_ready) carries one transaction per word bit:
//   serial_data, bit_index and latch_after, which is set on the last bit.
//   A raw command passes from the decode stage through the queue to the
//   serialiser; a digit command first runs the shift-and-add-3 conversion.
//   The serialiser emits one bit per cycle while the receiver is ready;
//   bits of successive words follow without a gap when the next is queued.
//   A two-entry queue lets the next command be decoded while a word shifts.
//   Reset empties the queue and drops any command in progress.
//   When the receiver stalls, the current bit holds and the serialiser waits;
//   commands are still taken until the queue and the decode stage are full.
// ----------------------------------------------------------------------------
module seven_segment_serial_display_driver
  import sssd_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [WORD_W-1:0]  value,
  input  logic [BAR_W-1:0]   bar,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               serial_data,
  output logic [INDEX_W-1:0] bit_index,
  output logic               latch_after
);

  logic              push_valid;
  logic              push_ready;
  logic [WORD_W-1:0] push_word;
  logic              pop_valid;
  logic              pop_ready;
  logic [WORD_W-1:0] pop_word;

  sssd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .value      (value),
    .bar        (bar),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word)
  );

  sssd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  sssd_back #(
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_word    (pop_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .serial_data (serial_data),
    .bit_index   (bit_index),
    .latch_after (latch_after)
  );

endmodule

### rtl/core/sssd_front.sv
// ----------------------------------------------------------------------------
// sssd_front
// Accepts commands, converts the number of a digit command to decimal digits
// by shift-and-add-3, builds the display word and pushes it to the queue.
// ----------------------------------------------------------------------------
module sssd_front
  import sssd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OPCODE_W-1:0] opcode,
  input  logic [WORD_W-1:0]   value,
  input  logic [BAR_W-1:0]    bar,
  output logic                push_valid,
  input  logic                push_ready,
  output logic [WORD_W-1:0]   push_word
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_PUSH = 3'b100
  } front_state_t;

  front_state_t      state, state_next;
  opcode_t           op;
  logic [WORD_W-1:0] val;
  logic [BAR_W-1:0]  bar_q;
  logic [BCD_W-1:0]  bcd;
  logic [BCD_W-1:0]  bcd_adj;
  logic [STEP_W-1:0] step;
  logic              accept;
  logic              is_digits;
  logic              in_digits;
  logic [WORD_W-1:0] digits_word;

  assign in_ready   = (state == S_IDLE) || ((state == S_PUSH) && push_ready);
  assign accept     = in_valid && in_ready;
  assign in_digits  = (opcode_t'(opcode) == OP_BAR) || (opcode_t'(opcode) == OP_DP);
  assign is_digits  = (op == OP_BAR) || (op == OP_DP);
  assign push_valid = (state == S_PUSH);

  always_comb begin
    for (int i = 0; i < BCD_W / 4; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    digits_word = {outer_digit(bcd[11:8]), 16'h0000}
                | {16'h0000, middle_digit(bcd[7:4])}
                | {16'h0000, outer_digit(bcd[3:0])};
    if (op == OP_BAR) begin
      digits_word = digits_word | {bar_leds(bar_q), 16'h0000};
    end else begin
      digits_word = digits_word | DP_MIDDLE;
    end
    push_word = is_digits ? digits_word : val;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = in_digits ? S_CONV : S_PUSH;
      end
      S_CONV: begin
        if (step == STEP_W'(BIN_W - 1)) state_next = S_PUSH;
      end
      S_PUSH: begin
        if (accept) begin
          state_next = in_digits ? S_CONV : S_PUSH;
        end else if (push_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op    <= opcode_t'(opcode);
      val   <= value;
      bar_q <= bar;
      bcd   <= '0;
      step  <= '0;
    end else if (state == S_CONV) begin
      bcd  <= {bcd_adj[BCD_W-2:0], val[BIN_W-1]};
      val  <= {val[WORD_W-1:BIN_W], val[BIN_W-2:0], 1'b0};
      step <= step + STEP_W'(1);
    end
  end

endmodule

### rtl/core/sssd_queue.sv
// ----------------------------------------------------------------------------
// sssd_queue
// Two-entry word queue between command decode and the serialiser.
// ----------------------------------------------------------------------------
module sssd_queue
  import sssd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [WORD_W-1:0] push_word,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [WORD_W-1:0] pop_word
);

  logic [WORD_W-1:0] entry [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_word   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_word;
    end
  end

endmodule

### rtl/core/sssd_back.sv
// ----------------------------------------------------------------------------
// sssd_back
// Serialiser: shifts each queued word out LSB first, one bit per transaction,
// flagging the last bit for the latch pulse.
// ----------------------------------------------------------------------------
module sssd_back
  import sssd_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  logic [WORD_W-1:0]  pop_word,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               serial_data,
  output logic [INDEX_W-1:0] bit_index,
  output logic               latch_after
);

  localparam int CNT_W = (WORD_BITS > 32) ? $clog2(WORD_BITS) : INDEX_W;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(WORD_BITS - 1);

  logic              active;
  logic [WORD_W-1:0] shift;
  logic [CNT_W-1:0]  pos;
  logic              adv;

  assign adv       = !out_valid || out_ready;
  assign pop_ready = adv && !active;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      if (active) begin
        out_valid <= 1'b1;
        if (pos == LAST) active <= 1'b0;
      end else if (pop_valid) begin
        out_valid <= 1'b1;
        active    <= 1'b1;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (active) begin
        serial_data <= shift[0];
        shift       <= shift >> 1;
        bit_index   <= pos[INDEX_W-1:0];
        latch_after <= (pos == LAST);
        pos         <= pos + CNT_W'(1);
      end else if (pop_valid) begin
        serial_data <= pop_word[0];
        shift       <= pop_word >> 1;
        bit_index   <= '0;
        latch_after <= 1'b0;
        pos         <= CNT_W'(1);
      end
    end
  end

endmodule

### verif/sssd_scoreboard_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sssd_scoreboard_pkg
// Predicts the display word of each command and checks the serial bits.
// Every accepted command becomes a queue of expected bits. Each bit that
// leaves the driver is compared, field by field, with the oldest one.
// ----------------------------------------------------------------------------
package sssd_scoreboard_pkg;

  import sssd_pkg::*;

  typedef struct packed {
    logic               data;
    logic [INDEX_W-1:0] index;
    logic               latch;
  } shifted_bit_t;

  class serial_word_scoreboard;

    int unsigned  word_bits;
    int unsigned  mismatches;
    shifted_bit_t awaited_bits[$];

    function new(int unsigned bits);
      word_bits  = bits;
      mismatches = 0;
    endfunction

    // Segment patterns of an outer display, PCDE--------GFAB.
    function logic [15:0] outer_segments(int unsigned d);
      case (d)
        0:       return 16'h7007;
        1:       return 16'h4001;
        2:       return 16'h300B;
        3:       return 16'h600B;
        4:       return 16'h400D;
        5:       return 16'h600E;
        6:       return 16'h700E;
        7:       return 16'h4003;
        8:       return 16'h700F;
        default: return 16'h600F;
      endcase
    endfunction

    // Segment patterns of the middle display, ----PCDEGFAB----.
    function logic [15:0] middle_segments(int unsigned d);
      case (d)
        0:       return 16'h0770;
        1:       return 16'h0410;
        2:       return 16'h03B0;
        3:       return 16'h06B0;
        4:       return 16'h04D0;
        5:       return 16'h06E0;
        6:       return 16'h07E0;
        7:       return 16'h0430;
        8:       return 16'h07F0;
        default: return 16'h06F0;
      endcase
    endfunction

    function logic [15:0] bar_segments(logic [BAR_W-1:0] b);
      logic [15:0] leds;
      leds = 16'h0000;
      if (b >= 4'd1 && b <= 4'd4) begin
        leds = 16'h0100 << 0;
        leds = ((16'h1 << b) - 16'h1) << 8;
      end else if (b >= 4'd5 && b <= 4'd8) begin
        leds = 16'h0F00 | (((16'h1 << (b - 4'd4)) - 16'h1) << (8 - (b - 4'd4)));
      end
      return leds;
    endfunction

    function logic [WORD_W-1:0] display_word(opcode_t op, logic [WORD_W-1:0] val,
                                             logic [BAR_W-1:0] b);
      int unsigned       n;
      logic [WORD_W-1:0] digits;
      n      = val[15:0];
      digits = {outer_segments((n / 100) % 10), 16'h0000}
             | {16'h0000, middle_segments((n / 10) % 10)}
             | {16'h0000, outer_segments(n % 10)};
      case (op)
        OP_BAR:  return digits | {bar_segments(b), 16'h0000};
        OP_DP:   return digits | DP_MIDDLE;
        default: return val;
      endcase
    endfunction

    function void note_command(opcode_t op, logic [WORD_W-1:0] val, logic [BAR_W-1:0] b);
      logic [WORD_W-1:0] word;
      shifted_bit_t      sb;
      word = display_word(op, val, b);
      for (int unsigned i = 0; i < word_bits; i++) begin
        sb.data  = (i < WORD_W) ? word[i] : 1'b0;
        sb.index = INDEX_W'(i % 32);
        sb.latch = (i == word_bits - 1);
        awaited_bits.push_back(sb);
      end
    endfunction

    function void check_bit(logic data, logic [INDEX_W-1:0] index, logic latch);
      shifted_bit_t want;
      if (awaited_bits.size() == 0) begin
        $error("serial bit with nothing awaited: data %0b index %0d latch %0b",
               data, index, latch);
        mismatches++;
        return;
      end
      want = awaited_bits.pop_front();
      if (data !== want.data) begin
        $error("serial_data: expected %0b, got %0b", want.data, data);
        mismatches++;
      end
      if (index !== want.index) begin
        $error("bit_index: expected %0d, got %0d", want.index, index);
        mismatches++;
      end
      if (latch !== want.latch) begin
        $error("latch_after: expected %0b, got %0b", want.latch, latch);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return awaited_bits.size();
    endfunction

  endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Random and directed test of the seven-segment serial display driver.
// Raw, bar-graph and decimal-point commands go in with random gaps; every
// serial bit coming out is checked against the predicted word while the
// receiver stalls at random.
// ----------------------------------------------------------------------------
module tb_top;

  import sssd_pkg::*;
  import sssd_scoreboard_pkg::*;

  localparam int RANDOM_COMMANDS = 350;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [OPCODE_W-1:0] opcode    = OP_RAW;
  logic [WORD_W-1:0]   value     = '0;
  logic [BAR_W-1:0]    bar       = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                serial_data;
  logic [INDEX_W-1:0]  bit_index;
  logic                latch_after;

  serial_word_scoreboard sb;
  bit                    quiet = 1'b0;
  int unsigned           ready_hold = 0;

  seven_segment_serial_display_driver #(
    .WORD_BITS (WORD_BITS_DEF)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .value       (value),
    .bar         (bar),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .serial_data (serial_data),
    .bit_index   (bit_index),
    .latch_after (latch_after)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: check each bit transaction, then at times stall for a random spell.
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      ready_hold = 0;
    end else if (out_valid && out_ready) begin
      sb.check_bit(serial_data, bit_index, latch_after);
      ready_hold = (quiet || $urandom_range(0, 3) != 0) ? 0 : $urandom_range(1, 17);
      out_ready <= (ready_hold == 0);
    end else if (!out_ready) begin
      if (ready_hold != 0) ready_hold--;
      if (ready_hold == 0) out_ready <= 1'b1;
    end
  end

  task automatic send_command(input opcode_t op, input logic [WORD_W-1:0] val,
                              input logic [BAR_W-1:0] b);
    int unsigned gap;
    gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : $urandom_range(1, 17);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    value    <= val;
    bar      <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_command(op, val, b);
  endtask

  // Hold the sender until every expected bit has gone out.
  task automatic drain_words();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic send_random_command();
    opcode_t           op;
    logic [WORD_W-1:0] val;
    logic [BAR_W-1:0]  b;
    int unsigned       pick;
    pick = $urandom_range(0, 9);
    if (pick < 3)      op = OP_RAW;
    else if (pick < 6) op = OP_BAR;
    else if (pick < 9) op = OP_DP;
    else               op = OP_UNUSED;
    val = $urandom();
    if ($urandom_range(0, 1) == 1) val[15:0] = 16'($urandom_range(0, 999));
    b = ($urandom_range(0, 3) == 0) ? BAR_W'($urandom_range(0, 15))
                                    : BAR_W'($urandom_range(0, 9));
    send_command(op, val, b);
  endtask

  initial begin
    sb = new(WORD_BITS_DEF);
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_command(OP_RAW,    32'h0000_0000, 4'd0);
    send_command(OP_RAW,    32'hFFFF_FFFF, 4'd15);
    send_command(OP_RAW,    32'hA5A5_5A5A, 4'd9);
    send_command(OP_UNUSED, 32'h1234_5678, 4'd3);
    send_command(OP_BAR,    32'd0,         4'd0);
    send_command(OP_BAR,    32'd999,       4'd8);
    send_command(OP_BAR,    32'd888,       4'd9);
    send_command(OP_BAR,    32'd123,       4'd15);
    send_command(OP_BAR,    32'd65535,     4'd5);
    send_command(OP_BAR,    32'hFFFF_0456, 4'd1);
    send_command(OP_BAR,    32'd567,       4'd2);
    send_command(OP_BAR,    32'd890,       4'd3);
    send_command(OP_BAR,    32'd1234,      4'd4);
    send_command(OP_BAR,    32'd40321,     4'd6);
    send_command(OP_BAR,    32'd7,         4'd7);
    send_command(OP_BAR,    32'd18,        4'd12);
    send_command(OP_DP,     32'd0,         4'd0);
    send_command(OP_DP,     32'd808,       4'd8);
    send_command(OP_DP,     32'd65535,     4'd9);
    send_command(OP_DP,     32'hFFFF_FFFF, 4'd15);
    send_command(OP_DP,     32'd99,        4'd4);
    send_command(OP_DP,     32'd10000,     4'd2);
    send_command(OP_DP,     32'd345,       4'd1);
    drain_words();

    for (int i = 0; i < RANDOM_COMMANDS; i++) begin
      quiet = (i >= 100 && i < 140) || (i >= 260 && i < 280);
      if (i == 200) drain_words();
      send_random_command();
    end
    quiet = 1'b0;

    drain_words();
    repeat (60) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
rtl/core/sssd_pkg.sv
rtl/core/sssd_front.sv
rtl/core/sssd_queue.sv
rtl/core/sssd_back.sv
rtl/core/seven_segment_serial_display_driver.sv
verif/sssd_scoreboard_pkg.sv
verif/tb_top.sv
